@@ sv/sga_pkg.sv @@
// Shared types and constants of the snow grid automaton.
`default_nettype none

package sga_pkg;

	// Command codes of the input channel.
	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_LEFT  = 3'd1,
		CMD_RIGHT = 3'd2,
		CMD_FIRE  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// Cell kinds reported by a read.
	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_FLAKE  = 2'd1,
		KIND_CANNON = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK_BOT,
		ST_TICK_CUR,
		ST_TICK_SCAN,
		ST_TICK_WB,
		ST_TICK_LAST,
		ST_FIRE,
		ST_READ,
		ST_FINISH
	} state_t;

	// Reset value of the tie-break LFSR.
	localparam logic [15:0] SEED_RESET = 16'd44257;

	// Neighborhood of the cell under the scan: current row and row below.
	typedef struct packed {
		logic cur_c;
		logic cur_l;
		logic cur_r;
		logic blw_c;
		logic blw_l;
		logic blw_r;
		logic at_left;
		logic at_right;
	} nbr_t;

	// Update of one scan step.
	typedef struct packed {
		logic clear_cur;
		logic set_c;
		logic set_l;
		logic set_r;
		logic tie_used;
	} move_t;

endpackage

`default_nettype wire

@@ sv/sga_row_mem.sv @@
// Row memory of the flake grid: one write port, one registered read port.
`default_nettype none

module sga_row_mem #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Rows never written read as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ sv/sga_col_step.sv @@
// Flake rule for one cell of the tick scan.
`default_nettype none

module sga_col_step (
	input  sga_pkg::nbr_t  nbr,
	input  logic           tie_left,
	output sga_pkg::move_t mv
);

	logic lblk;
	logic rblk;

	always_comb begin
		lblk = nbr.at_left || nbr.cur_l || nbr.blw_l;
		rblk = nbr.at_right || nbr.cur_r || nbr.blw_r;
		mv = '0;
		if (nbr.cur_c) begin
			if (!nbr.blw_c) begin
				mv.clear_cur = 1'b1;
				mv.set_c     = 1'b1;
			end else if (!(lblk && rblk)) begin
				mv.clear_cur = 1'b1;
				if (!lblk && !rblk) begin
					mv.tie_used = 1'b1;
					mv.set_l    = tie_left;
					mv.set_r    = !tie_left;
				end else if (rblk) begin
					mv.set_l = 1'b1;
				end else begin
					mv.set_r = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/snow_grid_automaton_unit.sv @@
// Top level of the snow grid automaton: sequencer, scan registers, cannon and LFSR.
`default_nettype none

// Falling-snow grid of GRID_WIDTH columns by GRID_HEIGHT rows, flakes in rows 1 and
// below, with a cannon on row 0. The grid sits in a row-wide synchronous memory;
// every command gives exactly one result transfer. Cannon moves, unknown commands
// and reads of row 0 or outside the grid need no memory access; a cell read of a
// grid row below the cannon reads that row, and fire reads row 1, then writes it
// back with the flake added if the cell under the cannon is empty. A tick reads
// the bottom row, then for each row from GRID_HEIGHT-2 up to 1 loads it, steps over
// its columns right to left one column per cycle, and writes the finished row below
// back. The row memory port pair allows the write-back of one row and the read
// of the next in the same cycle. Rows never written read as empty through per-row
// valid bits, so no clearing pass follows reset. Input is taken only while the
// sequencer idles; a finished result waits in an output register, so the next
// command is accepted before the last result is taken. The seed register port is
// always ready and loads the tie-break LFSR at once; the user must write it only
// while idle, and the block itself does not enforce this.
module snow_grid_automaton_unit #(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_HEIGHT = 32,
	localparam int CW = $clog2(GRID_WIDTH),
	localparam int RW = $clog2(GRID_HEIGHT)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [5:0]  read_column,
	input  logic [4:0]  read_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        succeeded,
	output logic [1:0]  cell_kind,
	output logic [5:0]  cannon_column,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] random_seed
);

	sga_pkg::state_t state_q;
	sga_pkg::state_t state_d;

	// Scan registers: row being emptied and the row it falls into.
	logic [GRID_WIDTH-1:0] cur_q;
	logic [GRID_WIDTH-1:0] below_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic [CW-1:0]         l_idx;
	logic [CW-1:0]         r_idx;

	logic [5:0]  cannon_q;
	logic [CW-1:0] cannon_idx;
	logic [15:0] lfsr_q;
	logic [15:0] lfsr_next;

	// Read command decode.
	logic [8:0]    row_ext;
	logic [6:0]    col_ext;
	logic          rd_hit;
	logic [CW-1:0] rd_col_q;

	// Pending result and output register.
	logic            res_ok_q;
	sga_pkg::kind_t  res_kind_q;
	logic            out_valid_q;
	logic            succeeded_q;
	sga_pkg::kind_t  cell_kind_q;
	logic [5:0]      cannon_col_q;
	logic            out_free;
	logic            accept;

	// Memory ports.
	logic                  wr_en;
	logic [RW-1:0]         wr_addr;
	logic [GRID_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [RW-1:0]         rd_addr;
	logic [GRID_WIDTH-1:0] rd_data;
	logic [GRID_WIDTH-1:0] fire_bit;

	sga_pkg::nbr_t  nbr;
	sga_pkg::move_t mv;

	sga_row_mem #(
		.WIDTH (GRID_WIDTH),
		.DEPTH (GRID_HEIGHT)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sga_col_step u_step (
		.nbr      (nbr),
		.tie_left (lfsr_q[0]),
		.mv       (mv)
	);

	assign in_stall  = (state_q != sga_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign succeeded     = succeeded_q;
	assign cell_kind     = cell_kind_q;
	assign cannon_column = cannon_col_q;

	assign row_ext    = {4'd0, read_row};
	assign col_ext    = {1'b0, read_column};
	assign rd_hit     = (row_ext < 9'(GRID_HEIGHT)) && (col_ext < 7'(GRID_WIDTH));
	assign cannon_idx = cannon_q[CW-1:0];

	// Fibonacci LFSR, taps 16,14,13,11, shifting right.
	assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

	always_comb begin
		fire_bit             = '0;
		fire_bit[cannon_idx] = 1'b1;
	end

	// Neighbor columns; walls are flagged separately so the index stays in range.
	assign l_idx = (col_q == '0) ? col_q : col_q - CW'(1);
	assign r_idx = (col_q == CW'(GRID_WIDTH - 1)) ? col_q : col_q + CW'(1);

	always_comb begin
		nbr.cur_c    = cur_q[col_q];
		nbr.cur_l    = cur_q[l_idx];
		nbr.cur_r    = cur_q[r_idx];
		nbr.blw_c    = below_q[col_q];
		nbr.blw_l    = below_q[l_idx];
		nbr.blw_r    = below_q[r_idx];
		nbr.at_left  = (col_q == '0);
		nbr.at_right = (col_q == CW'(GRID_WIDTH - 1));
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sga_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = below_q;
		unique case (state_q)
			sga_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (command)
						sga_pkg::CMD_TICK: begin
							rd_en   = 1'b1;
							rd_addr = RW'(GRID_HEIGHT - 1);
							state_d = sga_pkg::ST_TICK_BOT;
						end
						sga_pkg::CMD_FIRE: begin
							rd_en   = 1'b1;
							rd_addr = RW'(1);
							state_d = sga_pkg::ST_FIRE;
						end
						sga_pkg::CMD_READ: begin
							if (rd_hit && (read_row != '0)) begin
								rd_en   = 1'b1;
								rd_addr = row_ext[RW-1:0];
								state_d = sga_pkg::ST_READ;
							end else begin
								state_d = sga_pkg::ST_FINISH;
							end
						end
						default: state_d = sga_pkg::ST_FINISH;
					endcase
				end
			end
			sga_pkg::ST_TICK_BOT: begin
				rd_en   = 1'b1;
				rd_addr = RW'(GRID_HEIGHT - 2);
				state_d = sga_pkg::ST_TICK_CUR;
			end
			sga_pkg::ST_TICK_CUR: begin
				state_d = sga_pkg::ST_TICK_SCAN;
			end
			sga_pkg::ST_TICK_SCAN: begin
				if (col_q == '0) begin
					state_d = sga_pkg::ST_TICK_WB;
				end
			end
			sga_pkg::ST_TICK_WB: begin
				// Row below is final; fetch the next row up, if any, in the same cycle.
				wr_en   = 1'b1;
				wr_addr = row_q + RW'(1);
				wr_data = below_q;
				if (row_q == RW'(1)) begin
					state_d = sga_pkg::ST_TICK_LAST;
				end else begin
					rd_en   = 1'b1;
					rd_addr = row_q - RW'(1);
					state_d = sga_pkg::ST_TICK_CUR;
				end
			end
			sga_pkg::ST_TICK_LAST: begin
				wr_en   = 1'b1;
				wr_addr = RW'(1);
				wr_data = below_q;
				state_d = sga_pkg::ST_FINISH;
			end
			sga_pkg::ST_FIRE: begin
				wr_en   = !rd_data[cannon_idx];
				wr_addr = RW'(1);
				wr_data = rd_data | fire_bit;
				state_d = sga_pkg::ST_FINISH;
			end
			sga_pkg::ST_READ: begin
				state_d = sga_pkg::ST_FINISH;
			end
			sga_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = sga_pkg::ST_IDLE;
				end
			end
			default: state_d = sga_pkg::ST_IDLE;
		endcase
	end

	// Control registers: cannon, LFSR, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cannon_q    <= '0;
			lfsr_q      <= sga_pkg::SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (command == sga_pkg::CMD_LEFT) && (cannon_q != '0)) begin
				cannon_q <= cannon_q - 6'd1;
			end
			if (accept && (command == sga_pkg::CMD_RIGHT)
					&& (cannon_q != 6'(GRID_WIDTH - 1))) begin
				cannon_q <= cannon_q + 6'd1;
			end
			// A seed write wins over a tie step.
			if (cfg_valid) begin
				lfsr_q <= random_seed;
			end else if ((state_q == sga_pkg::ST_TICK_SCAN) && mv.tie_used) begin
				lfsr_q <= lfsr_next;
			end
			if (state_q == sga_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_col_q <= col_ext[CW-1:0];
			if ((command == sga_pkg::CMD_READ) && rd_hit && (read_row == '0)
					&& (read_column == cannon_q)) begin
				res_kind_q <= sga_pkg::KIND_CANNON;
			end else begin
				res_kind_q <= sga_pkg::KIND_EMPTY;
			end
			case (command)
				sga_pkg::CMD_TICK:  res_ok_q <= 1'b1;
				sga_pkg::CMD_LEFT:  res_ok_q <= (cannon_q != '0);
				sga_pkg::CMD_RIGHT: res_ok_q <= (cannon_q != 6'(GRID_WIDTH - 1));
				sga_pkg::CMD_FIRE:  res_ok_q <= 1'b0;
				sga_pkg::CMD_READ:  res_ok_q <= 1'b1;
				default: res_ok_q <= 1'b0;
			endcase
		end
		case (state_q)
			sga_pkg::ST_TICK_BOT: begin
				below_q <= rd_data;
				row_q   <= RW'(GRID_HEIGHT - 2);
			end
			sga_pkg::ST_TICK_CUR: begin
				cur_q <= rd_data;
				col_q <= CW'(GRID_WIDTH - 1);
			end
			sga_pkg::ST_TICK_SCAN: begin
				if (mv.clear_cur) begin
					cur_q[col_q] <= 1'b0;
				end
				if (mv.set_c) begin
					below_q[col_q] <= 1'b1;
				end
				if (mv.set_l) begin
					below_q[l_idx] <= 1'b1;
				end
				if (mv.set_r) begin
					below_q[r_idx] <= 1'b1;
				end
				col_q <= col_q - CW'(1);
			end
			sga_pkg::ST_TICK_WB: begin
				below_q <= cur_q;
				row_q   <= row_q - RW'(1);
			end
			sga_pkg::ST_FIRE: begin
				res_ok_q <= !rd_data[cannon_idx];
			end
			sga_pkg::ST_READ: begin
				res_kind_q <= rd_data[rd_col_q] ? sga_pkg::KIND_FLAKE : sga_pkg::KIND_EMPTY;
			end
			sga_pkg::ST_FINISH: begin
				if (out_free) begin
					succeeded_q  <= res_ok_q;
					cell_kind_q  <= res_kind_q;
					cannon_col_q <= cannon_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// A scan step only moves flakes between the two rows, never loses or adds one.
	a_scan_keeps_flakes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sga_pkg::ST_TICK_SCAN) |=>
		(($countones(cur_q) + $countones(below_q))
			== $past($countones(cur_q) + $countones(below_q))))
		else $error("tick scan changed the flake count");

	a_no_same_row_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("row memory read and write hit the same row");

	a_cannon_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cannon_q <= 6'(GRID_WIDTH - 1))
		else $error("cannon left the grid");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sga_pkg::ST_FINISH))
		else $error("result raised outside the finish step");

	a_lfsr_moves_on_tie: assert property (@(posedge clk) disable iff (!arst_n)
		(lfsr_q != $past(lfsr_q)) |->
		($past(state_q == sga_pkg::ST_TICK_SCAN) || $past(cfg_valid)))
		else $error("LFSR advanced outside a tie");
`endif

endmodule

`default_nettype wire
